### src/edq_pkg.sv
// Shared types and constants for the deadline-ordered ready queue.
// Used by the interfaces, the cell, the cell row and the top level.
package edq_pkg;

  localparam int unsigned IdW    = 8;
  localparam int unsigned DlW    = 32;
  localparam int unsigned ReqW   = 3;
  localparam int unsigned CountW = 5;

  typedef logic [ReqW-1:0] req_code_t;

  localparam req_code_t REQ_INSERT   = 3'd0;
  localparam req_code_t REQ_REMOVE   = 3'd1;
  localparam req_code_t REQ_REPOS    = 3'd2;
  localparam req_code_t REQ_POP_HEAD = 3'd3;
  localparam req_code_t REQ_SET_SLP  = 3'd4;
  localparam req_code_t REQ_PICK     = 3'd5;
  localparam req_code_t REQ_LOOKUP   = 3'd6;

  // One queue slot
  typedef struct packed {
    logic [IdW-1:0] id;
    logic [DlW-1:0] deadline;
    logic           sleep;
  } entry_t;

  // Broadcast search key seen by every cell
  typedef struct packed {
    logic [IdW-1:0] id;
    logic [DlW-1:0] deadline;
    logic [IdW-1:0] null_id;
  } key_t;

  // Per-cell compare results
  typedef struct packed {
    logic id_eq;
    logic dl_gt;
    logic ready;
  } cell_flags_t;

  typedef struct packed {
    req_code_t      req_type;
    logic [IdW-1:0] task_id;
    logic [DlW-1:0] deadline;
    logic           sleeping;
  } req_t;

  typedef struct packed {
    logic              ok;
    logic [IdW-1:0]    task_id;
    logic [DlW-1:0]    deadline;
    logic              sleeping;
    logic [CountW-1:0] count;
  } rsp_t;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_LOAD_NEW,
    OP_FROM_LEFT,
    OP_FROM_RIGHT,
    OP_SET_SLEEP
  } cell_op_e;

endpackage

### src/edq_req_if.sv
// Request channel of the ready queue: valid/ready plus the request fields.
// Depends on edq_pkg.
interface edq_req_if;
  import edq_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [ReqW-1:0]        req_type;
  logic [IdW-1:0]         task_id;
  logic [DlW-1:0]         deadline;
  logic                   sleeping;

  modport source (output valid, req_type, task_id, deadline, sleeping, input ready);
  modport sink   (input valid, req_type, task_id, deadline, sleeping, output ready);
endinterface

### src/edq_rsp_if.sv
// Response channel of the ready queue: valid/ready plus the result fields.
// Depends on edq_pkg.
interface edq_rsp_if;
  import edq_pkg::*;

  logic                   valid;
  logic                   ready;
  logic                   ok;
  logic [IdW-1:0]         task_id_out;
  logic [DlW-1:0]         deadline_out;
  logic                   sleeping_out;
  logic [CountW-1:0]      count;

  modport source (output valid, ok, task_id_out, deadline_out, sleeping_out, count,
                  input ready);
  modport sink   (input valid, ok, task_id_out, deadline_out, sleeping_out, count,
                  output ready);
endinterface

### src/edq_ready_queue.sv
// Earliest-deadline-first ready queue built from a row of shifting cells.
// Depends on edq_pkg, edq_req_if, edq_rsp_if and edq_chain.
//
// Usage:
//   req  - request transactions (insert, remove, reposition, remove head,
//          set sleep, pick, lookup), valid/ready handshake.
//   rsp  - one response transaction per request, valid/ready handshake,
//          held in an output register until taken.
//   cfg_we_i / cfg_wdata_i - write the null task id; write only while idle.
// Timing: a request is captured into a register and then executed across
// the cell row in the execute step; reposition adds an insert step because
// the entry is first taken out and then reinserted by its new deadline.
// The response appears in the cycle after execution. A new request is
// taken only in the idle state, once the last one has left the cell row.
// When the receiver stalls, a finished response stays in the output
// register and the next request waits in the execute step until the
// register frees.
// Reset empties the queue (count zero) and sets the null id to zero; the
// cell contents are not cleared and are never read beyond the count.
module edf_ready_queue #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  edq_req_if.sink              req,
  edq_rsp_if.source            rsp,
  input  logic                 cfg_we_i,
  input  logic [7:0]           cfg_wdata_i
);
  import edq_pkg::*;

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_INS  = 2'd2;

  logic [1:0]      state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic [IdW-1:0]  null_q;
  req_t            req_q;
  logic            keep_q, keep_d;
  logic            out_valid_q;
  rsp_t            rsp_q, rsp_d;
  logic            produce;
  logic            out_free;
  logic            req_fire;

  cell_op_e    [DEPTH-1:0] ops;
  entry_t      [DEPTH-1:0] entries;
  cell_flags_t [DEPTH-1:0] flags;
  entry_t                  new_entry;
  key_t                    key;

  logic [DEPTH-1:0] valid_v, match_v, ready_v, gt_v;
  logic [DEPTH-1:0] match_first, ready_first, rm_mask, gt_mask, ins_pt;
  entry_t           match_sel, ready_sel;
  logic             found, any_ready, has_room, not_empty;

  assign req_fire  = req.valid && req.ready;
  assign req.ready = (state_q == ST_IDLE);
  assign out_free  = !out_valid_q || rsp.ready;

  assign key.id       = req_q.task_id;
  assign key.deadline = req_q.deadline;
  assign key.null_id  = null_q;

  assign new_entry.id       = req_q.task_id;
  assign new_entry.deadline = req_q.deadline;
  assign new_entry.sleep    = (state_q == ST_INS) ? keep_q : req_q.sleeping;

  edq_chain #(.DEPTH(DEPTH)) u_chain (
    .clk_i   (clk_i),
    .op_i    (ops),
    .new_i   (new_entry),
    .key_i   (key),
    .entry_o (entries),
    .flags_o (flags)
  );

  // Per-cell masks and first-hit selection
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      valid_v[i] = CntW'(i) < count_q;
      match_v[i] = flags[i].id_eq && valid_v[i];
      ready_v[i] = flags[i].ready && valid_v[i];
      gt_v[i]    = flags[i].dl_gt;
    end
    match_first = match_v & (~match_v + DEPTH'(1));
    ready_first = ready_v & (~ready_v + DEPTH'(1));
    // everything from the hit onwards shifts towards the head
    rm_mask     = ~(match_first - DEPTH'(1));
    // suffix of later deadlines plus free slots; its lowest bit is the slot
    gt_mask     = gt_v | ~valid_v;
    ins_pt      = gt_mask & ~(gt_mask << 1);
    found       = |match_v;
    any_ready   = |ready_v;
    has_room    = count_q < CntW'(DEPTH);
    not_empty   = count_q != '0;
    match_sel   = '0;
    ready_sel   = '0;
    for (int i = 0; i < DEPTH; i++) begin
      match_sel = match_sel | (match_first[i] ? entries[i] : '0);
      ready_sel = ready_sel | (ready_first[i] ? entries[i] : '0);
    end
  end

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    keep_d  = keep_q;
    produce = 1'b0;
    rsp_d   = '0;
    for (int i = 0; i < DEPTH; i++) begin
      ops[i] = OP_HOLD;
    end

    case (state_q)
      ST_IDLE: begin
        if (req_fire) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (out_free) begin
          produce = 1'b1;
          state_d = ST_IDLE;
          case (req_q.req_type)
            REQ_INSERT: begin
              if (has_room) begin
                for (int i = 0; i < DEPTH; i++) begin
                  if (ins_pt[i]) begin
                    ops[i] = OP_LOAD_NEW;
                  end else if (gt_mask[i]) begin
                    ops[i] = OP_FROM_LEFT;
                  end
                end
                count_d  = count_q + CntW'(1);
                rsp_d.ok = 1'b1;
              end
            end
            REQ_REMOVE, REQ_REPOS: begin
              if (found) begin
                for (int i = 0; i < DEPTH; i++) begin
                  if (rm_mask[i]) begin
                    ops[i] = OP_FROM_RIGHT;
                  end
                end
                count_d  = count_q - CntW'(1);
                rsp_d.ok = 1'b1;
                if (req_q.req_type == REQ_REPOS) begin
                  // hold the result back until the entry is reinserted
                  keep_d  = match_sel.sleep;
                  produce = 1'b0;
                  state_d = ST_INS;
                end
              end
            end
            REQ_POP_HEAD: begin
              if (not_empty) begin
                for (int i = 0; i < DEPTH; i++) begin
                  ops[i] = OP_FROM_RIGHT;
                end
                count_d  = count_q - CntW'(1);
                rsp_d.ok = 1'b1;
              end
            end
            REQ_SET_SLP: begin
              for (int i = 0; i < DEPTH; i++) begin
                if (match_first[i]) begin
                  ops[i] = OP_SET_SLEEP;
                end
              end
              rsp_d.ok = found;
            end
            REQ_PICK: begin
              rsp_d.ok       = any_ready;
              rsp_d.task_id  = any_ready ? ready_sel.id : null_q;
              rsp_d.deadline = ready_sel.deadline;
            end
            REQ_LOOKUP: begin
              rsp_d.ok       = found;
              rsp_d.task_id  = found ? match_sel.id : null_q;
              rsp_d.deadline = match_sel.deadline;
              rsp_d.sleeping = match_sel.sleep;
            end
            default: begin
              rsp_d.ok = 1'b0;
            end
          endcase
        end
      end
      ST_INS: begin
        if (out_free) begin
          for (int i = 0; i < DEPTH; i++) begin
            if (ins_pt[i]) begin
              ops[i] = OP_LOAD_NEW;
            end else if (gt_mask[i]) begin
              ops[i] = OP_FROM_LEFT;
            end
          end
          count_d  = count_q + CntW'(1);
          rsp_d.ok = 1'b1;
          produce  = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    rsp_d.count = CountW'(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      null_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (cfg_we_i) begin
        null_q <= cfg_wdata_i;
      end
      if (produce) begin
        out_valid_q <= 1'b1;
      end else if (rsp.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    keep_q <= keep_d;
    if (req_fire) begin
      req_q.req_type <= req.req_type;
      req_q.task_id  <= req.task_id;
      req_q.deadline <= req.deadline;
      req_q.sleeping <= req.sleeping;
    end
    if (produce) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp.valid        = out_valid_q;
  assign rsp.ok           = rsp_q.ok;
  assign rsp.task_id_out  = rsp_q.task_id;
  assign rsp.deadline_out = rsp_q.deadline;
  assign rsp.sleeping_out = rsp_q.sleeping;
  assign rsp.count        = rsp_q.count;

endmodule

### src/edq_cell.sv
// One slot of the sorted queue: holds an entry, compares it with the key
// and takes a new entry, its left or right neighbour, or a new sleep flag.
// Depends on edq_pkg.
module edq_cell (
  input  logic                clk_i,
  input  edq_pkg::cell_op_e   op_i,
  input  edq_pkg::entry_t     new_i,
  input  edq_pkg::entry_t     left_i,
  input  edq_pkg::entry_t     right_i,
  input  edq_pkg::key_t       key_i,
  output edq_pkg::entry_t     entry_o,
  output edq_pkg::cell_flags_t flags_o
);
  import edq_pkg::*;

  entry_t entry_q, entry_d;

  always_comb begin
    entry_d = entry_q;
    case (op_i)
      OP_HOLD:       entry_d = entry_q;
      OP_LOAD_NEW:   entry_d = new_i;
      OP_FROM_LEFT:  entry_d = left_i;
      OP_FROM_RIGHT: entry_d = right_i;
      OP_SET_SLEEP:  entry_d.sleep = new_i.sleep;
      default:       entry_d = entry_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o       = entry_q;
  assign flags_o.id_eq = (entry_q.id == key_i.id);
  assign flags_o.dl_gt = (entry_q.deadline > key_i.deadline);
  assign flags_o.ready = !entry_q.sleep && (entry_q.id != key_i.null_id);

endmodule

### src/edq_chain.sv
// Row of DEPTH queue cells, head at index 0, each wired to its neighbours.
// Depends on edq_pkg and edq_cell.
module edq_chain #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                               clk_i,
  input  edq_pkg::cell_op_e    [DEPTH-1:0]   op_i,
  input  edq_pkg::entry_t                    new_i,
  input  edq_pkg::key_t                      key_i,
  output edq_pkg::entry_t      [DEPTH-1:0]   entry_o,
  output edq_pkg::cell_flags_t [DEPTH-1:0]   flags_o
);
  import edq_pkg::*;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    entry_t left, right;

    if (i == 0) begin : g_head
      assign left = new_i;
    end else begin : g_mid_l
      assign left = entry_o[i-1];
    end

    // the tail cell has no right neighbour: hold its own value
    if (i == DEPTH - 1) begin : g_tail
      assign right = entry_o[i];
    end else begin : g_mid_r
      assign right = entry_o[i+1];
    end

    edq_cell u_cell (
      .clk_i   (clk_i),
      .op_i    (op_i[i]),
      .new_i   (new_i),
      .left_i  (left),
      .right_i (right),
      .key_i   (key_i),
      .entry_o (entry_o[i]),
      .flags_o (flags_o[i])
    );
  end

endmodule
